// ===== rtl/magnetometer_minmax_calibration_top_macros.svh =====
// Assertion macros for the calibration block checker.
`ifndef MAGNETOMETER_MINMAX_CALIBRATION_TOP_MACROS_SVH
`define MAGNETOMETER_MINMAX_CALIBRATION_TOP_MACROS_SVH

// Check a consequence in the same cycle as its trigger.
`define MMC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("calibration check failed in the same cycle");

// Check a consequence in the cycle after its trigger.
`define MMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("calibration check failed one cycle later");

`endif

// ===== rtl/mmc_pkg.sv =====
package mmc_pkg;

  localparam int SAMPLE_BITS_DEF    = 16;
  localparam int GAIN_FRAC_BITS_DEF = 16;
  localparam int GAIN_BITS          = 24;
  localparam longint GAIN_MAX       = (longint'(1) << GAIN_BITS) - 1;
  localparam int AXES               = 3;
  localparam int MIN_START          = 9999;
  localparam int MAX_START          = -9999;

  typedef logic [1:0] axis_t;
  localparam axis_t AXIS_LAST = axis_t'(AXES - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_CORR,
    ST_RANGE,
    ST_DIV_LOAD,
    ST_DIV_STEP,
    ST_DIV_STORE,
    ST_WRITE
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic  ld_in;
    logic  do_start;
    logic  upd_minmax;
    logic  mul_en;
    logic  fin_en;
    logic  do_range;
    logic  div_load;
    logic  div_step;
    logic  div_store;
    logic  load_out;
    axis_t mul_axis;
    axis_t fin_axis;
    axis_t div_axis;
  } mmc_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic calibrating;
    logic degenerate;
    logic out_busy;
  } mmc_stat_t;

endpackage

// ===== rtl/magnetometer_minmax_calibration_top.sv =====
// Sample item: corrected in ST_CORR, then loaded into the output register from ST_WRITE;
//   the three axes share one multiplier, one axis a cycle, then truncate and saturate.
// Start item: restarts the trackers. Stop item: straight to ST_WRITE on fallback, else runs
//   the shared restoring divider per axis, one quotient bit a cycle, before ST_WRITE.
// One item is in work at a time; a finished result waits in the output register meanwhile.
// Synchronous active-low reset: not calibrating, trackers 9999/-9999, offsets 0, scales 1.0.
module magnetometer_minmax_calibration_top #(
  parameter int SAMPLE_BITS    = mmc_pkg::SAMPLE_BITS_DEF,
  parameter int GAIN_FRAC_BITS = mmc_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_command,
  input  logic signed [SAMPLE_BITS-1:0]  in_raw_x,
  input  logic signed [SAMPLE_BITS-1:0]  in_raw_y,
  input  logic signed [SAMPLE_BITS-1:0]  in_raw_z,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_BITS-1:0]  out_x,
  output logic signed [SAMPLE_BITS-1:0]  out_y,
  output logic signed [SAMPLE_BITS-1:0]  out_z,
  output logic signed [SAMPLE_BITS:0]    out_offset_half_x,
  output logic signed [SAMPLE_BITS:0]    out_offset_half_y,
  output logic signed [SAMPLE_BITS:0]    out_offset_half_z,
  output logic [mmc_pkg::GAIN_BITS-1:0]  out_gain_x,
  output logic [mmc_pkg::GAIN_BITS-1:0]  out_gain_y,
  output logic [mmc_pkg::GAIN_BITS-1:0]  out_gain_z,
  output logic                           out_new_extreme,
  output logic                           out_calib_done,
  output logic                           out_calib_fault
);
  import mmc_pkg::*;

  mmc_cmd_t  cmd;
  mmc_stat_t stat;

  // Sequence items
  mmc_ctrl #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Track, divide, correct and hold results
  mmc_datapath #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_command        (in_command),
    .in_raw_x          (in_raw_x),
    .in_raw_y          (in_raw_y),
    .in_raw_z          (in_raw_z),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_x             (out_x),
    .out_y             (out_y),
    .out_z             (out_z),
    .out_offset_half_x (out_offset_half_x),
    .out_offset_half_y (out_offset_half_y),
    .out_offset_half_z (out_offset_half_z),
    .out_gain_x        (out_gain_x),
    .out_gain_y        (out_gain_y),
    .out_gain_z        (out_gain_z),
    .out_new_extreme   (out_new_extreme),
    .out_calib_done    (out_calib_done),
    .out_calib_fault   (out_calib_fault)
  );

endmodule

// ===== rtl/mmc_ctrl.sv =====
module mmc_ctrl #(
  parameter int SAMPLE_BITS    = mmc_pkg::SAMPLE_BITS_DEF,
  parameter int GAIN_FRAC_BITS = mmc_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_command,
  output logic              in_stall,
  input  mmc_pkg::mmc_stat_t stat,
  output mmc_pkg::mmc_cmd_t  cmd
);
  import mmc_pkg::*;

  localparam int NUM_W = SAMPLE_BITS + 2 + GAIN_FRAC_BITS;
  localparam int STEP_W = $clog2(NUM_W);

  state_t            state_r, state_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  axis_t             axis_r, axis_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      axis_r  <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      axis_r  <= axis_nxt;
      step_r  <= step_nxt;
    end
  end

  // Sequence each item through the datapath
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    axis_nxt     = axis_r;
    step_nxt     = step_r;
    cmd          = '0;
    cmd.mul_axis = axis_t'(cnt_r);
    cmd.fin_axis = axis_t'(cnt_r - 2'd1);
    cmd.div_axis = axis_r;
    in_stall     = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          cnt_nxt   = '0;
          axis_nxt  = '0;
          if (!in_command) begin
            state_nxt = ST_CORR;
          end else if (stat.calibrating) begin
            state_nxt = ST_RANGE;
          end else begin
            state_nxt = ST_START;
          end
        end
      end
      ST_START: begin
        cmd.do_start = 1'b1;
        state_nxt    = ST_WRITE;
      end
      ST_CORR: begin
        // multiply axis cnt while finishing axis cnt-1
        cmd.upd_minmax = (cnt_r == 2'd0);
        cmd.mul_en     = (cnt_r != 2'd3);
        cmd.fin_en     = (cnt_r != 2'd0);
        cnt_nxt        = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_RANGE: begin
        cmd.do_range = 1'b1;
        state_nxt    = stat.degenerate ? ST_WRITE : ST_DIV_LOAD;
      end
      ST_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        step_nxt     = '0;
        state_nxt    = ST_DIV_STEP;
      end
      ST_DIV_STEP: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + STEP_W'(1);
        if (step_r == STEP_W'(NUM_W - 1)) begin
          state_nxt = ST_DIV_STORE;
        end
      end
      ST_DIV_STORE: begin
        cmd.div_store = 1'b1;
        axis_nxt      = axis_r + axis_t'(1);
        state_nxt     = (axis_r == AXIS_LAST) ? ST_WRITE : ST_DIV_LOAD;
      end
      ST_WRITE: begin
        // hold until the output register is free
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/mmc_datapath.sv =====
module mmc_datapath #(
  parameter int SAMPLE_BITS    = mmc_pkg::SAMPLE_BITS_DEF,
  parameter int GAIN_FRAC_BITS = mmc_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mmc_pkg::mmc_cmd_t              cmd,
  output mmc_pkg::mmc_stat_t             stat,
  input  logic                           in_command,
  input  logic signed [SAMPLE_BITS-1:0]  in_raw_x,
  input  logic signed [SAMPLE_BITS-1:0]  in_raw_y,
  input  logic signed [SAMPLE_BITS-1:0]  in_raw_z,
  input  logic                           out_stall,
  output logic                           out_valid,
  output logic signed [SAMPLE_BITS-1:0]  out_x,
  output logic signed [SAMPLE_BITS-1:0]  out_y,
  output logic signed [SAMPLE_BITS-1:0]  out_z,
  output logic signed [SAMPLE_BITS:0]    out_offset_half_x,
  output logic signed [SAMPLE_BITS:0]    out_offset_half_y,
  output logic signed [SAMPLE_BITS:0]    out_offset_half_z,
  output logic [mmc_pkg::GAIN_BITS-1:0]  out_gain_x,
  output logic [mmc_pkg::GAIN_BITS-1:0]  out_gain_y,
  output logic [mmc_pkg::GAIN_BITS-1:0]  out_gain_z,
  output logic                           out_new_extreme,
  output logic                           out_calib_done,
  output logic                           out_calib_fault
);
  import mmc_pkg::*;

  localparam int S      = SAMPLE_BITS;
  localparam int MM_W   = (S > 15) ? S : 15;
  localparam int RNG_W  = MM_W + 1;
  localparam int OFF_W  = S + 1;
  localparam int SUM_W  = S + 2;
  localparam int DEN_W  = S + 2;
  localparam int NUM_W  = S + 2 + GAIN_FRAC_BITS;
  localparam int QW     = (NUM_W > GAIN_BITS) ? NUM_W : GAIN_BITS;
  localparam int DIF_W  = S + 2;
  localparam int PW     = DIF_W + GAIN_BITS + 1;
  localparam int K      = GAIN_FRAC_BITS + 1;

  localparam longint G1_L = longint'(1) << GAIN_FRAC_BITS;
  localparam longint G2_L = longint'(2) << GAIN_FRAC_BITS;
  localparam logic [GAIN_BITS-1:0] GAIN_ONE =
    (G1_L > GAIN_MAX) ? GAIN_BITS'(GAIN_MAX) : GAIN_BITS'(G1_L);
  localparam logic [GAIN_BITS-1:0] GAIN_TWO =
    (G2_L > GAIN_MAX) ? GAIN_BITS'(GAIN_MAX) : GAIN_BITS'(G2_L);
  localparam logic signed [MM_W-1:0] MIN_INIT = MM_W'(MIN_START);
  localparam logic signed [MM_W-1:0] MAX_INIT = MM_W'(MAX_START);
  localparam logic signed [PW-1:0]   RND      = (PW'(1) << K) - PW'(1);
  localparam logic signed [PW-1:0]   LIM_HI   = (PW'(1) << (S - 1)) - PW'(1);
  localparam logic signed [PW-1:0]   LIM_LO   = ~LIM_HI;

  // item and calibration state
  logic                    cmd_in_r, cmd_in_nxt;
  logic signed [S-1:0]     raw_r [AXES];
  logic signed [S-1:0]     raw_nxt [AXES];
  logic                    calib_r, calib_nxt;
  logic                    usecorr_r, usecorr_nxt;
  logic signed [MM_W-1:0]  min_r [AXES];
  logic signed [MM_W-1:0]  min_nxt [AXES];
  logic signed [MM_W-1:0]  max_r [AXES];
  logic signed [MM_W-1:0]  max_nxt [AXES];
  logic signed [OFF_W-1:0] off_r [AXES];
  logic signed [OFF_W-1:0] off_nxt [AXES];
  logic [GAIN_BITS-1:0]    gain_r [AXES];
  logic [GAIN_BITS-1:0]    gain_nxt [AXES];
  logic                    ext_r, ext_nxt;
  logic                    done_r, done_nxt;
  logic                    fault_r, fault_nxt;

  // correction unit
  logic signed [PW-1:0]    prod_r, prod_nxt;
  logic signed [S-1:0]     res_r [AXES];
  logic signed [S-1:0]     res_nxt [AXES];

  // divider
  logic [S-1:0]            range_r [AXES];
  logic [S-1:0]            range_nxt [AXES];
  logic [NUM_W-1:0]        num_r, num_nxt;
  logic [DEN_W-1:0]        den_r, den_nxt;
  logic [DEN_W-1:0]        rem_r, rem_nxt;
  logic [NUM_W-1:0]        quo_r, quo_nxt;

  // output register
  logic                    ov_r, ov_nxt;
  logic signed [S-1:0]     ox_r, ox_nxt, oy_r, oy_nxt, oz_r, oz_nxt;
  logic signed [OFF_W-1:0] oox_r, oox_nxt, ooy_r, ooy_nxt, ooz_r, ooz_nxt;
  logic [GAIN_BITS-1:0]    ogx_r, ogx_nxt, ogy_r, ogy_nxt, ogz_r, ogz_nxt;
  logic                    oext_r, oext_nxt, odone_r, odone_nxt, ofault_r, ofault_nxt;

  // combinational helpers
  logic signed [MM_W-1:0]  raw_mm [AXES];
  logic signed [RNG_W-1:0] r_full [AXES];
  logic                    empty_c, zero_c;
  logic signed [DIF_W-1:0] dif_c;
  logic signed [GAIN_BITS:0] gsig_c;
  logic signed [PW-1:0]    prod_c;
  logic signed [PW-1:0]    adj_c, shr_c;
  logic signed [S-1:0]     sat_c;
  logic [SUM_W-1:0]        sum_c;
  logic [DEN_W-1:0]        rng_d;
  logic [DEN_W:0]          rem_sh;
  logic                    qbit;
  logic [QW-1:0]           quo_ext;
  logic [GAIN_BITS-1:0]    quo_sat;

  // Ranges and fault flags of the trackers
  always_comb begin
    empty_c = 1'b0;
    zero_c  = 1'b0;
    for (int a = 0; a < AXES; a++) begin
      raw_mm[a] = MM_W'(raw_r[a]);
      r_full[a] = RNG_W'(max_r[a]) - RNG_W'(min_r[a]);
      if (r_full[a] < 0) begin
        empty_c = 1'b1;
      end else if (r_full[a] == 0) begin
        zero_c = 1'b1;
      end
    end
  end

  // Multiply one axis: (2*raw - offset) * gain
  assign dif_c  = (DIF_W'(raw_r[cmd.mul_axis]) <<< 1) - DIF_W'(off_r[cmd.mul_axis]);
  assign gsig_c = signed'({1'b0, gain_r[cmd.mul_axis]});
  assign prod_c = PW'(dif_c) * PW'(gsig_c);

  // Truncate toward zero and saturate the registered product
  assign adj_c = prod_r + (prod_r[PW-1] ? RND : '0);
  assign shr_c = adj_c >>> K;
  always_comb begin
    if (shr_c > LIM_HI) begin
      sat_c = S'(LIM_HI);
    end else if (shr_c < LIM_LO) begin
      sat_c = S'(LIM_LO);
    end else begin
      sat_c = S'(shr_c);
    end
  end

  // Divider operands and one restoring step
  assign sum_c   = SUM_W'(range_r[0]) + SUM_W'(range_r[1]) + SUM_W'(range_r[2]);
  assign rng_d   = DEN_W'(range_r[cmd.div_axis]);
  assign rem_sh  = {rem_r, num_r[NUM_W-1]};
  assign qbit    = (rem_sh >= {1'b0, den_r});
  assign quo_ext = QW'(quo_r);
  assign quo_sat = (quo_ext > QW'(GAIN_MAX)) ? GAIN_BITS'(GAIN_MAX) : GAIN_BITS'(quo_r);

  assign stat.calibrating = calib_r;
  assign stat.degenerate  = empty_c | zero_c;
  assign stat.out_busy    = ov_r & out_stall;

  // Next state of all registers
  always_comb begin
    cmd_in_nxt  = cmd_in_r;
    calib_nxt   = calib_r;
    usecorr_nxt = usecorr_r;
    ext_nxt     = ext_r;
    done_nxt    = done_r;
    fault_nxt   = fault_r;
    prod_nxt    = prod_r;
    num_nxt     = num_r;
    den_nxt     = den_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    for (int a = 0; a < AXES; a++) begin
      raw_nxt[a]   = raw_r[a];
      min_nxt[a]   = min_r[a];
      max_nxt[a]   = max_r[a];
      off_nxt[a]   = off_r[a];
      gain_nxt[a]  = gain_r[a];
      res_nxt[a]   = res_r[a];
      range_nxt[a] = range_r[a];
    end
    ov_nxt     = ov_r & out_stall;
    ox_nxt     = ox_r;
    oy_nxt     = oy_r;
    oz_nxt     = oz_r;
    oox_nxt    = oox_r;
    ooy_nxt    = ooy_r;
    ooz_nxt    = ooz_r;
    ogx_nxt    = ogx_r;
    ogy_nxt    = ogy_r;
    ogz_nxt    = ogz_r;
    oext_nxt   = oext_r;
    odone_nxt  = odone_r;
    ofault_nxt = ofault_r;

    // capture the item and clear its flags
    if (cmd.ld_in) begin
      cmd_in_nxt = in_command;
      raw_nxt[0] = in_raw_x;
      raw_nxt[1] = in_raw_y;
      raw_nxt[2] = in_raw_z;
      ext_nxt    = 1'b0;
      done_nxt   = 1'b0;
      fault_nxt  = 1'b0;
    end

    // restart the trackers
    if (cmd.do_start) begin
      calib_nxt   = 1'b1;
      usecorr_nxt = 1'b0;
      for (int a = 0; a < AXES; a++) begin
        min_nxt[a] = MIN_INIT;
        max_nxt[a] = MAX_INIT;
      end
    end

    // widen the trackers
    if (cmd.upd_minmax && calib_r) begin
      for (int a = 0; a < AXES; a++) begin
        if (raw_mm[a] < min_r[a]) begin
          min_nxt[a] = raw_mm[a];
          ext_nxt    = 1'b1;
        end
        if (raw_mm[a] > max_r[a]) begin
          max_nxt[a] = raw_mm[a];
          ext_nxt    = 1'b1;
        end
      end
    end

    if (cmd.mul_en) begin
      prod_nxt = prod_c;
    end
    if (cmd.fin_en) begin
      res_nxt[cmd.fin_axis] = usecorr_r ? sat_c : raw_r[cmd.fin_axis];
    end

    // end calibration; apply fallback values when a range is empty or zero
    if (cmd.do_range) begin
      calib_nxt   = 1'b0;
      usecorr_nxt = 1'b1;
      done_nxt    = 1'b1;
      for (int a = 0; a < AXES; a++) begin
        range_nxt[a] = r_full[a][S-1:0];
      end
      if (empty_c || zero_c) begin
        fault_nxt = ~empty_c;
        for (int a = 0; a < AXES; a++) begin
          off_nxt[a]  = '0;
          gain_nxt[a] = empty_c ? GAIN_ONE : GAIN_TWO;
        end
      end
    end

    // divide (sum << frac) by 3 * range, one quotient bit a cycle
    if (cmd.div_load) begin
      num_nxt = NUM_W'(sum_c) << GAIN_FRAC_BITS;
      den_nxt = rng_d + (rng_d << 1);
      rem_nxt = '0;
      quo_nxt = '0;
    end
    if (cmd.div_step) begin
      rem_nxt = qbit ? DEN_W'(rem_sh - {1'b0, den_r}) : DEN_W'(rem_sh);
      num_nxt = num_r << 1;
      quo_nxt = {quo_r[NUM_W-2:0], qbit};
    end
    if (cmd.div_store) begin
      gain_nxt[cmd.div_axis] = quo_sat;
      off_nxt[cmd.div_axis]  = OFF_W'(max_r[cmd.div_axis]) + OFF_W'(min_r[cmd.div_axis]);
    end

    // load the result item
    if (cmd.load_out) begin
      ov_nxt     = 1'b1;
      ox_nxt     = cmd_in_r ? '0 : res_r[0];
      oy_nxt     = cmd_in_r ? '0 : res_r[1];
      oz_nxt     = cmd_in_r ? '0 : res_r[2];
      oox_nxt    = off_r[0];
      ooy_nxt    = off_r[1];
      ooz_nxt    = off_r[2];
      ogx_nxt    = gain_r[0];
      ogy_nxt    = gain_r[1];
      ogz_nxt    = gain_r[2];
      oext_nxt   = ext_r;
      odone_nxt  = done_r;
      ofault_nxt = fault_r;
    end
  end

  // Control and calibration state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calib_r   <= 1'b0;
      usecorr_r <= 1'b0;
      ov_r      <= 1'b0;
      for (int a = 0; a < AXES; a++) begin
        min_r[a]  <= MIN_INIT;
        max_r[a]  <= MAX_INIT;
        off_r[a]  <= '0;
        gain_r[a] <= GAIN_ONE;
      end
    end else begin
      calib_r   <= calib_nxt;
      usecorr_r <= usecorr_nxt;
      ov_r      <= ov_nxt;
      for (int a = 0; a < AXES; a++) begin
        min_r[a]  <= min_nxt[a];
        max_r[a]  <= max_nxt[a];
        off_r[a]  <= off_nxt[a];
        gain_r[a] <= gain_nxt[a];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_in_r <= cmd_in_nxt;
    ext_r    <= ext_nxt;
    done_r   <= done_nxt;
    fault_r  <= fault_nxt;
    prod_r   <= prod_nxt;
    num_r    <= num_nxt;
    den_r    <= den_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    for (int a = 0; a < AXES; a++) begin
      raw_r[a]   <= raw_nxt[a];
      res_r[a]   <= res_nxt[a];
      range_r[a] <= range_nxt[a];
    end
    ox_r     <= ox_nxt;
    oy_r     <= oy_nxt;
    oz_r     <= oz_nxt;
    oox_r    <= oox_nxt;
    ooy_r    <= ooy_nxt;
    ooz_r    <= ooz_nxt;
    ogx_r    <= ogx_nxt;
    ogy_r    <= ogy_nxt;
    ogz_r    <= ogz_nxt;
    oext_r   <= oext_nxt;
    odone_r  <= odone_nxt;
    ofault_r <= ofault_nxt;
  end

  assign out_valid         = ov_r;
  assign out_x             = ox_r;
  assign out_y             = oy_r;
  assign out_z             = oz_r;
  assign out_offset_half_x = oox_r;
  assign out_offset_half_y = ooy_r;
  assign out_offset_half_z = ooz_r;
  assign out_gain_x        = ogx_r;
  assign out_gain_y        = ogy_r;
  assign out_gain_z        = ogz_r;
  assign out_new_extreme   = oext_r;
  assign out_calib_done    = odone_r;
  assign out_calib_fault   = ofault_r;

endmodule

// ===== rtl/mmc_checker.sv =====
`include "magnetometer_minmax_calibration_top_macros.svh"

module mmc_checker #(
  parameter int SAMPLE_BITS = mmc_pkg::SAMPLE_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [SAMPLE_BITS-1:0] out_x,
  input logic signed [SAMPLE_BITS-1:0] out_y,
  input logic signed [SAMPLE_BITS-1:0] out_z,
  input logic signed [SAMPLE_BITS:0]   out_offset_half_x,
  input logic signed [SAMPLE_BITS:0]   out_offset_half_y,
  input logic signed [SAMPLE_BITS:0]   out_offset_half_z,
  input logic [mmc_pkg::GAIN_BITS-1:0] out_gain_x,
  input logic [mmc_pkg::GAIN_BITS-1:0] out_gain_y,
  input logic [mmc_pkg::GAIN_BITS-1:0] out_gain_z,
  input logic                          out_new_extreme,
  input logic                          out_calib_done,
  input logic                          out_calib_fault
);

  // Hold a stalled result item
  `MMC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z) && $stable(out_gain_x) && $stable(out_calib_done))

  // A stop item carries no sample and no new extreme
  `MMC_ASSERT_SAME(a_done_clean, clk, rst_n, out_valid && out_calib_done, !out_new_extreme && out_x == 0 && out_y == 0 && out_z == 0)

  // A fault stop applies equal scales and zero offsets
  `MMC_ASSERT_SAME(a_fault_vals, clk, rst_n, out_valid && out_calib_fault, out_calib_done && out_offset_half_x == 0 && out_offset_half_y == 0 && out_offset_half_z == 0 && out_gain_x == out_gain_y && out_gain_y == out_gain_z)

  // Busy right after taking an item
  `MMC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

endmodule

bind magnetometer_minmax_calibration_top mmc_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_mmc_checker (.*);

// ===== tb/sv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mmc_pkg::*;

  localparam int SB          = SAMPLE_BITS_DEF;
  localparam int GFB         = GAIN_FRAC_BITS_DEF;
  localparam int GAIN_ONE    = 1 << GFB;
  localparam int GAIN_TWO    = 2 << GFB;
  localparam int NUM_DIRECTED = 25;
  localparam int RANDOM_PER_PHASE = 610;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 250;
  localparam int TAIL_CYCLES = 200;
  localparam int CYCLE_LIMIT = 1000000;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_TOGGLE = 1'b1
  } mag_cmd_e;

  typedef logic [AXES-1:0][SB-1:0] raw_set_t;

  typedef struct packed {
    logic [AXES-1:0][SB-1:0]        corr;
    logic [AXES-1:0][SB:0]          offs;
    logic [AXES-1:0][GAIN_BITS-1:0] gain;
    logic                           extreme;
    logic                           done;
    logic                           fault;
  } calib_result_t;

  typedef struct {
    mag_cmd_e cmd;
    int       raw [AXES];
    bit       typed;
    int       corr [AXES];
    int       offs;
    int       gain;
    bit       extreme;
    bit       done;
    bit       fault;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_command = 1'b0;
  logic signed [SB-1:0] in_raw_x = '0;
  logic signed [SB-1:0] in_raw_y = '0;
  logic signed [SB-1:0] in_raw_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SB-1:0] out_x, out_y, out_z;
  logic signed [SB:0] out_offset_half_x, out_offset_half_y, out_offset_half_z;
  logic [GAIN_BITS-1:0] out_gain_x, out_gain_y, out_gain_z;
  logic out_new_extreme, out_calib_done, out_calib_fault;

  // Mirror of the calibration state, advanced on each accepted item
  logic               cal_active;
  logic               cal_in_use;
  longint             trk_min [AXES];
  longint             trk_max [AXES];
  logic signed [SB:0] cal_offset [AXES];
  logic [GAIN_BITS-1:0] cal_gain [AXES];

  calib_result_t expected_results [$];
  int items_sent = 0;
  int results_seen = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int gap_pct = 33;
  int stall_pct = 51;
  bit held_once = 1'b0;
  string axis_tag [AXES] = '{"x", "y", "z"};

  // Rows with typed results are those readable at a glance: reset values,
  // the empty stop, the zero-range fallback and the scale-by-two case.
  directed_row_t directed_rows [NUM_DIRECTED] = '{
    '{CMD_SAMPLE, '{32767, -32768, 0}, 1, '{32767, -32768, 0}, 0, GAIN_ONE, 0, 0, 0},
    '{CMD_TOGGLE, '{-1, -1, -1}, 1, '{0, 0, 0}, 0, GAIN_ONE, 0, 0, 0},
    '{CMD_TOGGLE, '{-1, -1, -1}, 1, '{0, 0, 0}, 0, GAIN_ONE, 0, 1, 0},
    '{CMD_SAMPLE, '{32767, -32768, -1}, 1, '{32767, -32768, -1}, 0, GAIN_ONE, 0, 0, 0},
    '{CMD_TOGGLE, '{-1, -1, -1}, 1, '{0, 0, 0}, 0, GAIN_ONE, 0, 0, 0},
    '{CMD_SAMPLE, '{5, 5, 5}, 1, '{5, 5, 5}, 0, GAIN_ONE, 1, 0, 0},
    '{CMD_SAMPLE, '{5, 5, 5}, 1, '{5, 5, 5}, 0, GAIN_ONE, 0, 0, 0},
    '{CMD_TOGGLE, '{-1, -1, -1}, 1, '{0, 0, 0}, 0, GAIN_TWO, 0, 1, 1},
    '{CMD_SAMPLE, '{32767, -32768, 100}, 1, '{32767, -32768, 200}, 0, GAIN_TWO, 0, 0, 0},
    '{CMD_TOGGLE, '{-1, -1, -1}, 1, '{0, 0, 0}, 0, GAIN_TWO, 0, 0, 0},
    '{CMD_SAMPLE, '{-32768, -32768, -32768}, 0, '{0, 0, 0}, 0, 0, 0, 0, 0},
    '{CMD_SAMPLE, '{32767, 32767, 32767}, 0, '{0, 0, 0}, 0, 0, 0, 0, 0},
    '{CMD_SAMPLE, '{0, 100, -100}, 0, '{0, 0, 0}, 0, 0, 0, 0, 0},
    '{CMD_TOGGLE, '{0, 0, 0}, 0, '{0, 0, 0}, 0, 0, 0, 0, 0},
    '{CMD_SAMPLE, '{32767, -32768, 0}, 0, '{0, 0, 0}, 0, 0, 0, 0, 0},
    '{CMD_SAMPLE, '{1, -1, 0}, 0, '{0, 0, 0}, 0, 0, 0, 0, 0},
    '{CMD_TOGGLE, '{0, 0, 0}, 0, '{0, 0, 0}, 0, 0, 0, 0, 0},
    '{CMD_SAMPLE, '{9999, -9999, 0}, 0, '{0, 0, 0}, 0, 0, 0, 0, 0},
    '{CMD_TOGGLE, '{0, 0, 0}, 0, '{0, 0, 0}, 0, 0, 0, 0, 0},
    '{CMD_TOGGLE, '{0, 0, 0}, 0, '{0, 0, 0}, 0, 0, 0, 0, 0},
    '{CMD_SAMPLE, '{0, -32768, -32768}, 0, '{0, 0, 0}, 0, 0, 0, 0, 0},
    '{CMD_SAMPLE, '{1, 32767, 32767}, 0, '{0, 0, 0}, 0, 0, 0, 0, 0},
    '{CMD_TOGGLE, '{0, 0, 0}, 0, '{0, 0, 0}, 0, 0, 0, 0, 0},
    '{CMD_SAMPLE, '{32767, 0, -32768}, 0, '{0, 0, 0}, 0, 0, 0, 0, 0},
    '{CMD_SAMPLE, '{-32768, 1, -1}, 0, '{0, 0, 0}, 0, 0, 0, 0, 0}
  };

  magnetometer_minmax_calibration_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_raw_x          (in_raw_x),
    .in_raw_y          (in_raw_y),
    .in_raw_z          (in_raw_z),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_x             (out_x),
    .out_y             (out_y),
    .out_z             (out_z),
    .out_offset_half_x (out_offset_half_x),
    .out_offset_half_y (out_offset_half_y),
    .out_offset_half_z (out_offset_half_z),
    .out_gain_x        (out_gain_x),
    .out_gain_y        (out_gain_y),
    .out_gain_z        (out_gain_z),
    .out_new_extreme   (out_new_extreme),
    .out_calib_done    (out_calib_done),
    .out_calib_fault   (out_calib_fault)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Clamp a scale to the 24-bit register
  function automatic logic [GAIN_BITS-1:0] sat_gain(longint g);
    return (g > GAIN_MAX) ? GAIN_BITS'(GAIN_MAX) : GAIN_BITS'(g);
  endfunction

  // Apply hard- and soft-iron correction to one axis, truncate toward zero
  function automatic logic [SB-1:0] corrected_axis(logic [SB-1:0] raw, int a);
    longint lim_hi, lim_lo, num, mag, v;
    lim_hi = (longint'(1) << (SB - 1)) - 1;
    lim_lo = -lim_hi - 1;
    if (cal_in_use) begin
      num = (2 * longint'($signed(raw)) - longint'(cal_offset[a])) * longint'(cal_gain[a]);
      mag = (num < 0) ? -num : num;
      mag = mag >> (GFB + 1);
      v = (num < 0) ? -mag : mag;
    end else begin
      v = longint'($signed(raw));
    end
    if (v > lim_hi) v = lim_hi;
    if (v < lim_lo) v = lim_lo;
    return SB'(v);
  endfunction

  // Advance the calibration state by one item and return the result it yields
  function automatic calib_result_t calib_predict(mag_cmd_e cmd, raw_set_t raw);
    calib_result_t r;
    longint span [AXES];
    longint total, v;
    bit empty, zero;
    r = '0;
    if (cmd == CMD_TOGGLE) begin
      if (cal_active) begin
        empty = 1'b0;
        zero = 1'b0;
        total = 0;
        for (int a = 0; a < AXES; a++) begin
          span[a] = trk_max[a] - trk_min[a];
          if (span[a] < 0) empty = 1'b1;
          else if (span[a] == 0) zero = 1'b1;
          total += span[a];
        end
        cal_active = 1'b0;
        cal_in_use = 1'b1;
        for (int a = 0; a < AXES; a++) begin
          if (empty || zero) begin
            cal_offset[a] = '0;
            cal_gain[a] = sat_gain(longint'(empty ? 1 : 2) << GFB);
          end else begin
            cal_offset[a] = (SB + 1)'(trk_max[a] + trk_min[a]);
            cal_gain[a] = sat_gain((total << GFB) / (3 * span[a]));
          end
        end
        r.done = 1'b1;
        r.fault = zero && !empty;
      end else begin
        cal_active = 1'b1;
        cal_in_use = 1'b0;
        for (int a = 0; a < AXES; a++) begin
          trk_min[a] = MIN_START;
          trk_max[a] = MAX_START;
        end
      end
    end else begin
      for (int a = 0; a < AXES; a++) begin
        r.corr[a] = corrected_axis(raw[a], a);
        if (cal_active) begin
          v = longint'($signed(raw[a]));
          if (v < trk_min[a]) begin
            trk_min[a] = v;
            r.extreme = 1'b1;
          end
          if (v > trk_max[a]) begin
            trk_max[a] = v;
            r.extreme = 1'b1;
          end
        end
      end
    end
    for (int a = 0; a < AXES; a++) begin
      r.offs[a] = cal_offset[a];
      r.gain[a] = cal_gain[a];
    end
    return r;
  endfunction

  function automatic raw_set_t random_raw();
    raw_set_t raw;
    for (int a = 0; a < AXES; a++) raw[a] = SB'($urandom);
    return raw;
  endfunction

  // Draw a value around base; a negative spread means the full range
  function automatic logic [SB-1:0] pick_raw(int base, int spread);
    int v;
    if (spread < 0) return SB'($urandom);
    v = base + int'($urandom_range(2 * spread)) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return SB'(v);
  endfunction

  // Offer one item, hold it until accepted, then record its expected result
  task automatic send_item(mag_cmd_e cmd, raw_set_t raw, bit typed = 1'b0,
                           calib_result_t typed_res = '0);
    calib_result_t predicted;
    while (int'($urandom_range(99)) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_raw_x   <= raw[0];
    in_raw_y   <= raw[1];
    in_raw_z   <= raw[2];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = calib_predict(cmd, raw);
    expected_results.push_back(typed ? typed_res : predicted);
    items_sent++;
  endtask

  // Start, a run of tracked samples, stop, then corrected samples
  task automatic run_session();
    int base [AXES];
    int spread [AXES];
    int n_cal, n_use, pick;
    raw_set_t raw;
    if (cal_active) send_item(CMD_TOGGLE, random_raw());
    n_cal = ($urandom_range(19) == 0) ? 0 : int'($urandom_range(1, 30));
    n_use = $urandom_range(1, 15);
    for (int a = 0; a < AXES; a++) begin
      if ($urandom_range(7) == 0)
        base[a] = ($urandom_range(1) ? MIN_START : MAX_START) + int'($urandom_range(2)) - 1;
      else
        base[a] = int'($urandom_range(65535)) - 32768;
      pick = $urandom_range(19);
      if (pick == 0) spread[a] = 0;
      else if (pick < 5) spread[a] = -1;
      else if (pick < 10) spread[a] = $urandom_range(1, 8);
      else spread[a] = $urandom_range(1, 4000);
    end
    send_item(CMD_TOGGLE, random_raw());
    repeat (n_cal) begin
      for (int a = 0; a < AXES; a++) raw[a] = pick_raw(base[a], spread[a]);
      send_item(CMD_SAMPLE, raw);
    end
    send_item(CMD_TOGGLE, random_raw());
    repeat (n_use) begin
      if ($urandom_range(4) == 0) begin
        raw = random_raw();
      end else begin
        for (int a = 0; a < AXES; a++)
          raw[a] = pick_raw(base[a], (spread[a] < 0) ? -1 : 2 * spread[a] + 50);
      end
      send_item(CMD_SAMPLE, raw);
    end
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Stimulus: reset, directed rows, then three phases of random sessions and single items, idle gaps in the first two
  initial begin : stimulus
    raw_set_t raw;
    calib_result_t typed_res;
    cal_active = 1'b0;
    cal_in_use = 1'b0;
    for (int a = 0; a < AXES; a++) begin
      trk_min[a] = MIN_START;
      trk_max[a] = MAX_START;
      cal_offset[a] = '0;
      cal_gain[a] = sat_gain(longint'(1) << GFB);
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      typed_res = '0;
      for (int a = 0; a < AXES; a++) begin
        raw[a] = SB'(directed_rows[i].raw[a]);
        typed_res.corr[a] = SB'(directed_rows[i].corr[a]);
        typed_res.offs[a] = (SB + 1)'(directed_rows[i].offs);
        typed_res.gain[a] = GAIN_BITS'(directed_rows[i].gain);
      end
      typed_res.extreme = directed_rows[i].extreme;
      typed_res.done = directed_rows[i].done;
      typed_res.fault = directed_rows[i].fault;
      send_item(directed_rows[i].cmd, raw, directed_rows[i].typed, typed_res);
    end

    for (int ph = 0; ph < 3; ph++) begin
      // Pause the sender until every outstanding result is back
      in_valid <= 1'b0;
      wait_drained();
      gap_pct   = (ph == 0) ? 33 : (ph == 1) ? 51 : 0;
      stall_pct = (ph == 0) ? 51 : (ph == 1) ? 33 : 0;
      while (items_sent < NUM_DIRECTED + (ph + 1) * RANDOM_PER_PHASE) begin
        if ($urandom_range(9) < 8) begin
          run_session();
        end else begin
          repeat ($urandom_range(1, 5))
            send_item(mag_cmd_e'($urandom_range(1)), random_raw());
        end
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off to back up the block
  initial begin : result_drain
    forever begin
      if (!held_once && results_seen >= HOLD_AT) begin
        held_once = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= (int'($urandom_range(99)) < stall_pct);
        @(posedge clk);
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : result_check
    calib_result_t got;
    calib_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.corr    = {out_z, out_y, out_x};
      got.offs    = {out_offset_half_z, out_offset_half_y, out_offset_half_x};
      got.gain    = {out_gain_z, out_gain_y, out_gain_x};
      got.extreme = out_new_extreme;
      got.done    = out_calib_done;
      got.fault   = out_calib_fault;
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result arrived with no item outstanding");
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        for (int a = 0; a < AXES; a++) begin
          check_field({"out_", axis_tag[a]}, $signed(want.corr[a]), $signed(got.corr[a]));
          check_field({"offset_half_", axis_tag[a]}, $signed(want.offs[a]),
                      $signed(got.offs[a]));
          check_field({"gain_", axis_tag[a]}, want.gain[a], got.gain[a]);
        end
        check_field("new_extreme", want.extreme, got.extreme);
        check_field("calib_done", want.done, got.done);
        check_field("calib_fault", want.fault, got.fault);
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/mmc_pkg.sv
rtl/mmc_ctrl.sv
rtl/mmc_datapath.sv
rtl/magnetometer_minmax_calibration_top.sv
rtl/mmc_checker.sv
tb/sv/tb_top.sv
